### hdl/neuron_accumulate_and_fire_macros.svh
// Assertion macros for the accumulate-and-fire block, used by nac_queue.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef NEURON_ACCUMULATE_AND_FIRE_MACROS_SVH
`define NEURON_ACCUMULATE_AND_FIRE_MACROS_SVH

// Checked on every clock edge outside reset.
`define NAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define NAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/nac_pkg.sv
// Types, codes and the sigmoid table for the neuron accumulate-and-fire block.
// No dependencies; imported by every module of the block.
package nac_pkg;

  localparam int VAL_W  = 16;                 // Q4.12 values
  localparam int ACC_W  = 24;                 // Q12.12 accumulator
  localparam int PROD_W = 2 * VAL_W - 12;     // product after >> 12

  localparam int SIGMOID_ENTRIES = 256;
  localparam int SIG_IDX_W  = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_PROD_W = VAL_W + $clog2(SIGMOID_ENTRIES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [VAL_W-1:0] ONE_Q12     = 16'sd4096;
  localparam logic signed [VAL_W-1:0] NEG_ONE_Q12 = -16'sd4096;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_FIRE  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [2:0] MODE_DIRECT     = 3'd0;
  localparam logic [2:0] MODE_BIAS       = 3'd1;
  localparam logic [2:0] MODE_PERCEPTRON = 3'd2;
  localparam logic [2:0] MODE_MCCULLOCH  = 3'd3;
  localparam logic [2:0] MODE_SIGMOID    = 3'd4;

  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_THRESHOLD    = 2'd1;
  localparam logic [1:0] REG_ACTIVE_OUT   = 2'd2;
  localparam logic [1:0] REG_INACTIVE_OUT = 2'd3;

  // Classified word handed from the front end to the execution side.
  typedef struct packed {
    action_t                   action;
    logic signed [VAL_W-1:0]   in_value;
    logic signed [PROD_W-1:0]  product;   // floor(weight * in_value / 4096)
  } nac_op_t;

  typedef logic signed [VAL_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

  // Shift-and-subtract quotient, only evaluated while the table is built.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(x/2) in Q4.12 for 0 <= xq <= 32768, exp by truncated Taylor series in Q30.
  function automatic longint unsigned half_tanh_pos(longint unsigned xq);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned num;
    longint unsigned den;
    longint unsigned one_q30;
    one_q30 = 64'd1073741824;
    term = one_q30;
    sum  = one_q30;
    for (int k = 1; k <= 40; k++) begin
      term = udiv64(term * xq, 64'd4096 * longint'(k));
      sum  = sum + term;
    end
    num = (sum - one_q30) * 64'd4096;
    den = sum + one_q30;
    return udiv64(num + (den >> 1), den);
  endfunction

  // Table sampled at the center of each input bucket.
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t      rom;
    longint        x;
    longint unsigned h;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      x = -64'sd32768 + ((2 * longint'(i) + 1) * 64'sd32768) / SIGMOID_ENTRIES;
      if (x < 0) begin
        h = half_tanh_pos(longint'(-x));
        rom[i] = -VAL_W'(h);
      end else begin
        h = half_tanh_pos(x);
        rom[i] = VAL_W'(h);
      end
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

### hdl/nac_front.sv
// Front end: takes input words, decodes the action and forms the scaled product.
// Depends on nac_pkg.
module nac_front
  import nac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] in_weight,
  output logic                    op_valid,
  input  logic                    op_ready,
  output nac_op_t                 op
);

  logic signed [2*VAL_W-1:0] full_prod;

  assign full_prod = (2*VAL_W)'(in_weight) * (2*VAL_W)'(in_value);
  assign in_ready  = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op.action   <= action_t'(in_action);
      op.in_value <= in_value;
      // arithmetic >> 12 floors
      op.product  <= full_prod[2*VAL_W-1:12];
    end
  end

endmodule

### hdl/nac_queue.sv
// Short FIFO of classified words between the front end and the execution side.
// Depends on nac_pkg and the assertion macro header.
`include "neuron_accumulate_and_fire_macros.svh"

module nac_queue
  import nac_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  nac_op_t push_op,
  output logic    pop_valid,
  input  logic    pop_ready,
  output nac_op_t pop_op
);

  nac_op_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  `NAC_ASSERT(a_push_only_when_room, (count == QCNT_W'(QUEUE_DEPTH)) |-> !push, "queue overrun")
  `NAC_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + QCNT_W'(1), "lost push")
  `NAC_ASSERT(a_count_down, (pop && !push) |=> count == $past(count) - QCNT_W'(1), "lost pop")
  `NAC_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")

endmodule

### hdl/nac_back.sv
// Execution side: accumulator, activation functions, config registers, output register.
// Depends on nac_pkg.
module nac_back
  import nac_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          op_valid,
  output logic          op_ready,
  input  nac_op_t       op,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,
  output logic [0:0]    m_tuser
);

  logic [2:0]              mode;
  logic signed [VAL_W-1:0] threshold;
  logic signed [VAL_W-1:0] active_out;
  logic signed [VAL_W-1:0] inactive_out;

  logic signed [ACC_W-1:0] acc;
  logic signed [VAL_W-1:0] act;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [VAL_W-1:0] act_next;
  logic                    fired_next;
  logic                    take;

  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [VAL_W-1:0] acc_clamp;
  logic signed [ACC_W:0]   acc_wide;
  logic signed [ACC_W:0]   thr_wide;
  logic signed [ACC_W:0]   neg_thr_wide;
  logic [VAL_W-1:0]        sig_v;
  logic [SIG_PROD_W-1:0]   sig_prod;
  logic [SIG_IDX_W-1:0]    sig_idx;
  logic signed [VAL_W-1:0] fire_val;

  assign op_ready = !m_tvalid || m_tready;
  assign take     = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_DIRECT;
      threshold    <= '0;
      active_out   <= ONE_Q12;
      inactive_out <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode         <= cfg_data[2:0];
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_ACTIVE_OUT:   active_out   <= cfg_data;
        REG_INACTIVE_OUT: inactive_out <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating add of the scaled product
  assign acc_sum = {acc[ACC_W-1], acc} +
                   {{(ACC_W + 1 - PROD_W){op.product[PROD_W-1]}}, op.product};
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // accumulator clamped to the Q4.12 range
  always_comb begin
    if (acc[ACC_W-1:VAL_W-1] == '0 || acc[ACC_W-1:VAL_W-1] == '1) begin
      acc_clamp = acc[VAL_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_clamp = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      acc_clamp = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign acc_wide     = {acc[ACC_W-1], acc};
  assign thr_wide     = {{(ACC_W + 1 - VAL_W){threshold[VAL_W-1]}}, threshold};
  assign neg_thr_wide = -thr_wide;

  // table index: (clamped + 32768) * entries >> 16
  assign sig_v    = {~acc_clamp[VAL_W-1], acc_clamp[VAL_W-2:0]};
  assign sig_prod = SIG_PROD_W'(sig_v) * SIG_PROD_W'(SIGMOID_ENTRIES);
  assign sig_idx  = sig_prod[VAL_W +: SIG_IDX_W];

  always_comb begin
    case (mode)
      MODE_DIRECT: fire_val = acc_clamp;
      MODE_BIAS:   fire_val = ONE_Q12;
      MODE_PERCEPTRON: begin
        if (acc_wide > thr_wide) begin
          fire_val = ONE_Q12;
        end else if (acc_wide < neg_thr_wide) begin
          fire_val = NEG_ONE_Q12;
        end else begin
          fire_val = '0;
        end
      end
      MODE_MCCULLOCH: fire_val = (acc_wide >= thr_wide) ? active_out : inactive_out;
      MODE_SIGMOID:   fire_val = SIG_ROM[sig_idx];
      default:        fire_val = act;   // undefined modes keep the activation
    endcase
  end

  always_comb begin
    acc_next   = acc;
    act_next   = act;
    fired_next = 1'b0;
    unique case (op.action)
      ACT_LOAD:  acc_next = {{(ACC_W - VAL_W){op.in_value[VAL_W-1]}}, op.in_value};
      ACT_ACCUM: acc_next = acc_sat;
      ACT_FIRE: begin
        act_next   = fire_val;
        fired_next = 1'b1;
      end
      ACT_NONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      act      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        acc <= acc_next;
        act <= act_next;
      end
      if (op_ready) begin
        m_tvalid <= op_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {acc_next, act_next};
      m_tuser <= fired_next;
    end
  end

endmodule

### hdl/neuron_accumulate_and_fire.sv
// Channel  | Dir | Fields (low bit up)
// s_       | in  | tdata: in_value[15:0], weight[31:16]; tuser: action[1:0]
// m_       | out | tdata: activation[15:0], acc_value[39:16]; tuser: fired[0]
// cfg_     | in  | index 0 mode, 1 threshold, 2 active_out, 3 inactive_out
//
// One word per cycle sustained while neither side stalls. A word passes
// the product register, one queue slot, and the output register.
// The accumulator update, a loop through the acc register alone, sets the rate.
// Synchronous rst clears acc, activation and valids; cfg regs get defaults.
// Either side may stall; the two-entry queue lets the front keep taking words.
module neuron_accumulate_and_fire
  import nac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // in_value[15:0], weight[31:16]
  input  logic [1:0]  s_tuser,    // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // activation[15:0], acc_value[39:16]
  output logic [0:0]  m_tuser,    // fired[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic    f_valid;
  logic    f_ready;
  nac_op_t f_op;
  logic    q_valid;
  logic    q_ready;
  nac_op_t q_op;

  nac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_value  (s_tdata[15:0]),
    .in_weight (s_tdata[31:16]),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  nac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  nac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op        (q_op),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
